/* hw/rtl/line_rasterizer_pixel_address_macros.svh */
// Assertion macros for the line rasterizer blocks.
`ifndef LINE_RASTERIZER_PIXEL_ADDRESS_MACROS_SVH
`define LINE_RASTERIZER_PIXEL_ADDRESS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LRPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LRPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lrpa_pkg.sv */
// Shared types and constants for the line rasterizer pixel address block.
`default_nettype none

package lrpa_pkg;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned BPP_W    = 6;
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned CFG_W    = 14;

  localparam logic [BPP_W-1:0]    BPP_RESET    = 6'd32;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd1600;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_BPP    = 1'b0,
    REG_STRIDE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic emit;
    logic last;
  } step_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/lrpa_stepper.sv */
// Bresenham stepper: holds the line state and produces the next pixel.
`default_nettype none

module lrpa_stepper #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     fire_i,
  input  wire                     op_i,
  input  wire [COORD_BITS-1:0]    x_start_i,
  input  wire [COORD_BITS-1:0]    y_start_i,
  input  wire [COORD_BITS-1:0]    x_end_i,
  input  wire [COORD_BITS-1:0]    y_end_i,
  output logic [COORD_BITS-1:0]   pix_x_o,
  output logic [COORD_BITS-1:0]   pix_y_o,
  output lrpa_pkg::step_ctrl_t    ctrl_o
);
  import lrpa_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;
  localparam logic [CB-1:0] ONE = {{(CB-1){1'b0}}, 1'b1};

  logic [CB-1:0] cur_x_q, cur_x_d;
  logic [CB-1:0] cur_y_q, cur_y_d;
  logic [EW-1:0] err_q, err_d;
  logic [CB-1:0] dx_q, dx_d;
  logic [CB-1:0] dy_q, dy_d;
  logic          xneg_q, xneg_d;
  logic          yneg_q, yneg_d;
  logic          xmaj_q, xmaj_d;
  logic [CB-1:0] steps_q, steps_d;
  logic          active_q, active_d;

  logic          x_gt, y_gt;
  logic [CB-1:0] sdx, sdy, smajor;
  logic          sxmaj;
  logic [CB-1:0] dmaj, dmin;
  logic [EW-1:0] err_sum, err_sub;
  logic          minor_move;
  logic [CB-1:0] mx, my;

  // Start: deltas and directions from the endpoints.
  assign x_gt   = x_end_i > x_start_i;
  assign y_gt   = y_end_i > y_start_i;
  assign sdx    = x_gt ? x_end_i - x_start_i : x_start_i - x_end_i;
  assign sdy    = y_gt ? y_end_i - y_start_i : y_start_i - y_end_i;
  assign sxmaj  = sdx > sdy;
  assign smajor = sxmaj ? sdx : sdy;

  // Step: one move on the major axis, maybe one on the minor.
  assign dmaj       = xmaj_q ? dx_q : dy_q;
  assign dmin       = xmaj_q ? dy_q : dx_q;
  assign err_sum    = err_q + {2'b00, dmin};
  assign minor_move = err_sum >= {2'b00, dmaj};
  assign err_sub    = err_sum - {2'b00, dmaj};
  assign mx         = xneg_q ? cur_x_q - ONE : cur_x_q + ONE;
  assign my         = yneg_q ? cur_y_q - ONE : cur_y_q + ONE;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_d    = err_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    xmaj_d   = xmaj_q;
    steps_d  = steps_q;
    active_d = active_q;
    ctrl_o   = '0;
    if (op_i == OP_START) begin
      cur_x_d     = x_start_i;
      cur_y_d     = y_start_i;
      dx_d        = sdx;
      dy_d        = sdy;
      xneg_d      = !x_gt;
      yneg_d      = !y_gt;
      xmaj_d      = sxmaj;
      err_d       = {3'b000, smajor[CB-1:1]};
      steps_d     = smajor;
      active_d    = smajor != '0;
      ctrl_o.emit = 1'b1;
      ctrl_o.last = smajor == '0;
    end else if (active_q) begin
      if (xmaj_q) begin
        cur_x_d = mx;
        if (minor_move) begin
          cur_y_d = my;
        end
      end else begin
        cur_y_d = my;
        if (minor_move) begin
          cur_x_d = mx;
        end
      end
      err_d       = minor_move ? err_sub : err_sum;
      steps_d     = steps_q - ONE;
      active_d    = steps_q != ONE;
      ctrl_o.emit = 1'b1;
      ctrl_o.last = steps_q == ONE;
    end
  end

  assign pix_x_o = cur_x_d;
  assign pix_y_o = cur_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      err_q    <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      xneg_q   <= 1'b0;
      yneg_q   <= 1'b0;
      xmaj_q   <= 1'b0;
      steps_q  <= '0;
      active_q <= 1'b0;
    end else if (fire_i) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      err_q    <= err_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      xneg_q   <= xneg_d;
      yneg_q   <= yneg_d;
      xmaj_q   <= xmaj_d;
      steps_q  <= steps_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lrpa_addr.sv */
// Frame-buffer byte address of a pixel's blue byte.
`default_nettype none

module lrpa_addr #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire [COORD_BITS-1:0]               x_i,
  input  wire [COORD_BITS-1:0]               y_i,
  input  wire [lrpa_pkg::BPP_W-1:0]          bpp_i,
  input  wire [lrpa_pkg::STRIDE_W-1:0]       stride_i,
  output logic [lrpa_pkg::ADDR_W-1:0]        addr_o
);
  import lrpa_pkg::*;

  localparam int unsigned XB_W  = COORD_BITS + BPP_W;
  localparam int unsigned YS_W  = COORD_BITS + STRIDE_W;
  localparam int unsigned SUM_W = (YS_W > ADDR_W) ? YS_W : ADDR_W;

  logic [XB_W-1:0]  x_bits;
  logic [YS_W-1:0]  y_bytes;
  logic [SUM_W-1:0] sum;

  assign x_bits  = {{BPP_W{1'b0}}, x_i} * {{COORD_BITS{1'b0}}, bpp_i};
  assign y_bytes = {{STRIDE_W{1'b0}}, y_i} * {{COORD_BITS{1'b0}}, stride_i};
  // Drop the fraction of a byte, then wrap to the address width.
  assign sum     = SUM_W'(x_bits[XB_W-1:3]) + SUM_W'(y_bytes);
  assign addr_o  = sum[ADDR_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/line_rasterizer_pixel_address.sv */
// Top level of the line rasterizer: Bresenham stepper with pixel address output.
// A result word passes through stage one and the output register after its input word is accepted.
// Throughput: one input word per cycle while in_stall_o is low; each start or active step gives one word.
// A step with no active line is accepted and gives no word.
// Reset clears the line state and pipeline valids; bits_per_pixel 32, stride 1600.
`default_nettype none

`include "line_rasterizer_pixel_address_macros.svh"

module line_rasterizer_pixel_address #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [0:0]                    cfg_index_i,
  input  wire [lrpa_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          op_i,
  input  wire [COORD_BITS-1:0]         x_start_i,
  input  wire [COORD_BITS-1:0]         y_start_i,
  input  wire [COORD_BITS-1:0]         x_end_i,
  input  wire [COORD_BITS-1:0]         y_end_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [COORD_BITS-1:0]        pixel_x_o,
  output logic [COORD_BITS-1:0]        pixel_y_o,
  output logic [lrpa_pkg::ADDR_W-1:0]  byte_address_o,
  output logic                         last_pixel_o
);
  import lrpa_pkg::*;

  logic [BPP_W-1:0]    bpp_q;
  logic [STRIDE_W-1:0] stride_q;

  logic                in_fire, out_ready, s1_load;
  logic [COORD_BITS-1:0] step_x, step_y;
  step_ctrl_t          step_ctrl;

  logic                  s1_valid_q, s1_valid_d;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                  s1_last_q;
  logic [ADDR_W-1:0]     s1_addr;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BPP_RESET;
      stride_q <= STRIDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BPP:    bpp_q    <= cfg_data_i[BPP_W-1:0];
        REG_STRIDE: stride_q <= cfg_data_i[STRIDE_W-1:0];
        default:    bpp_q    <= bpp_q;
      endcase
    end
  end

  // Output register frees when empty or taken; stage one holds only when it cannot drain.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_load    = !s1_valid_q || out_ready;

  lrpa_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .op_i      (op_i),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .pix_x_o   (step_x),
    .pix_y_o   (step_y),
    .ctrl_o    (step_ctrl)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = in_fire && step_ctrl.emit;
    end
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_fire) begin
      s1_x_q    <= step_x;
      s1_y_q    <= step_y;
      s1_last_q <= step_ctrl.last;
    end
  end

  lrpa_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .x_i      (s1_x_q),
    .y_i      (s1_y_q),
    .bpp_i    (bpp_q),
    .stride_i (stride_q),
    .addr_o   (s1_addr)
  );

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_addr_q <= s1_addr;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign byte_address_o = out_addr_q;
  assign last_pixel_o   = out_last_q;

  `LRPA_ASSERT(a_stall_needs_word, !in_stall_o || (s1_valid_q && out_valid_q), "input stalled without a held word")
  `LRPA_ASSERT_NEXT(a_start_emits, in_fire && (op_i == OP_START), s1_valid_q, "start gave no word")
  `LRPA_ASSERT_NEXT(a_point_is_last, in_fire && (op_i == OP_START) && (x_start_i == x_end_i) && (y_start_i == y_end_i), s1_last_q, "single-pixel line not marked last")

endmodule

`default_nettype wire

/* bench/line_rasterizer_pixel_address_checker.sv */
// Checker for the line rasterizer: predicts every pixel word and compares it with the output.
module line_rasterizer_pixel_address_checker #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [0:0]                    cfg_index_i,
  input  wire [lrpa_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  input  wire                          in_stall_i,
  input  wire                          op_i,
  input  wire [COORD_BITS-1:0]         x_start_i,
  input  wire [COORD_BITS-1:0]         y_start_i,
  input  wire [COORD_BITS-1:0]         x_end_i,
  input  wire [COORD_BITS-1:0]         y_end_i,
  input  wire                          out_valid_i,
  input  wire                          out_stall_i,
  input  wire [COORD_BITS-1:0]         pixel_x_i,
  input  wire [COORD_BITS-1:0]         pixel_y_i,
  input  wire [lrpa_pkg::ADDR_W-1:0]   byte_address_i,
  input  wire                          last_pixel_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import lrpa_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    logic [ADDR_W-1:0]   addr;
    logic                last;
  } pixel_t;

  pixel_t pixels_due [$];

  logic [BPP_W-1:0]      bpp;
  logic [STRIDE_W-1:0]   stride;
  coord_t                cur_x;
  coord_t                cur_y;
  coord_t                dx;
  coord_t                dy;
  coord_t                left;
  logic [COORD_BITS+1:0] err;
  logic                  x_neg;
  logic                  y_neg;
  logic                  x_major;
  logic                  active;
  int unsigned           fails;

  function automatic coord_t nudge(coord_t c, logic neg);
    return neg ? c - 1'b1 : c + 1'b1;
  endfunction

  // Address of the blue byte, wrapped to the address width.
  function automatic pixel_t locate_pixel(coord_t x, coord_t y, logic last,
                                          logic [BPP_W-1:0] b, logic [STRIDE_W-1:0] s);
    logic [31:0] offset;
    pixel_t      p;
    offset = (32'(x) * 32'(b)) / 32'd8 + 32'(y) * 32'(s);
    p.x    = x;
    p.y    = y;
    p.addr = offset[ADDR_W-1:0];
    p.last = last;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    pixel_t want;
    coord_t major;
    if (!rst_ni) begin
      pixels_due.delete();
      bpp     = BPP_RESET;
      stride  = STRIDE_RESET;
      cur_x   = '0;
      cur_y   = '0;
      dx      = '0;
      dy      = '0;
      left    = '0;
      err     = '0;
      x_neg   = 1'b0;
      y_neg   = 1'b0;
      x_major = 1'b0;
      active  = 1'b0;
      fails   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $error("pixel word with none expected: x=%0d y=%0d address=%0d",
                 pixel_x_i, pixel_y_i, byte_address_i);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          if (pixel_x_i !== want.x) begin
            $error("pixel_x mismatch: expected %0d, got %0d", want.x, pixel_x_i);
            fails++;
          end
          if (pixel_y_i !== want.y) begin
            $error("pixel_y mismatch: expected %0d, got %0d", want.y, pixel_y_i);
            fails++;
          end
          if (byte_address_i !== want.addr) begin
            $error("byte_address mismatch: expected %0d, got %0d", want.addr, byte_address_i);
            fails++;
          end
          if (last_pixel_i !== want.last) begin
            $error("last_pixel mismatch: expected %0d, got %0d", want.last, last_pixel_i);
            fails++;
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_index_i == REG_BPP) begin
          bpp = cfg_data_i[BPP_W-1:0];
        end else begin
          stride = cfg_data_i[STRIDE_W-1:0];
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_START) begin
          x_neg   = !(x_end_i > x_start_i);
          y_neg   = !(y_end_i > y_start_i);
          dx      = x_neg ? x_start_i - x_end_i : x_end_i - x_start_i;
          dy      = y_neg ? y_start_i - y_end_i : y_end_i - y_start_i;
          x_major = dx > dy;
          major   = x_major ? dx : dy;
          err     = (COORD_BITS+2)'(major >> 1);
          left    = major;
          cur_x   = x_start_i;
          cur_y   = y_start_i;
          active  = major != 0;
          pixels_due.push_back(locate_pixel(cur_x, cur_y, major == 0, bpp, stride));
        end else if (active) begin
          // advance the major axis; move the minor axis once the error reaches the major delta
          if (x_major) begin
            cur_x = nudge(cur_x, x_neg);
            err   = err + dy;
            if (err >= dx) begin
              err   = err - dx;
              cur_y = nudge(cur_y, y_neg);
            end
          end else begin
            cur_y = nudge(cur_y, y_neg);
            err   = err + dx;
            if (err >= dy) begin
              err   = err - dy;
              cur_x = nudge(cur_x, x_neg);
            end
          end
          left   = left - 1'b1;
          active = left != 0;
          pixels_due.push_back(locate_pixel(cur_x, cur_y, left == 0, bpp, stride));
        end
      end

      pending_o    <= pixels_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the line rasterizer: clock, reset, line stimulus and verdict.
module tb_top;
  import lrpa_pkg::*;

  localparam int unsigned COORD_BITS    = 10;
  localparam int          COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int          CHUNK_WORDS   = 120;
  localparam int unsigned HOLD_CYCLES   = 300;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  cfg_reg_e                 cfg_index  = REG_BPP;
  logic [CFG_W-1:0]         cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  op_e                      op         = OP_START;
  logic [COORD_BITS-1:0]    x_start    = '0;
  logic [COORD_BITS-1:0]    y_start    = '0;
  logic [COORD_BITS-1:0]    x_end      = '0;
  logic [COORD_BITS-1:0]    y_end      = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [COORD_BITS-1:0]    pixel_x;
  logic [COORD_BITS-1:0]    pixel_y;
  logic [ADDR_W-1:0]        byte_address;
  logic                     last_pixel;
  int unsigned              fail_count;
  int unsigned              pending;

  int                       sender_idle_pct = 0;
  int                       recv_idle_pct   = 0;
  int                       phase           = 0;
  int unsigned              hold_left;
  logic                     hold_done;
  int unsigned              quiet_cycles;

  int unsigned bpp_set    [9] = '{63, 0, 8, 24, 32, 16, 8, 63, 24};
  int unsigned stride_set [9] = '{16383, 0, 1600, 16383, 1, 640, 8191, 16383, 1024};

  always #5 clk = ~clk;

  line_rasterizer_pixel_address #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .x_end_i       (x_end),
    .y_end_i       (y_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .byte_address_o(byte_address),
    .last_pixel_o  (last_pixel)
  );

  line_rasterizer_pixel_address_checker #(
    .COORD_BITS(COORD_BITS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .x_end_i       (x_end),
    .y_end_i       (y_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .byte_address_i(byte_address),
    .last_pixel_i  (last_pixel),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Pixel sink: random stalls, plus one long hold-off when the no-idle phase begins.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_coord(int v);
    return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  // Offer one command word and hold it until the block takes it.
  task automatic offer_command(input op_e kind, input int xs, ys, xe, ye);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    x_start  <= COORD_BITS'(xs);
    y_start  <= COORD_BITS'(ys);
    x_end    <= COORD_BITS'(xe);
    y_end    <= COORD_BITS'(ye);
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic offer_step();
    offer_command(OP_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
  endtask

  // Wait until every predicted pixel has come out, then let the pipeline settle.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input int unsigned bpp, input int unsigned stride);
    logic [CFG_W-1:0] word;
    // junk in the bits above the pixel depth field must be dropped
    word             = CFG_W'($urandom);
    word[BPP_W-1:0]  = BPP_W'(bpp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BPP;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= REG_STRIDE;
    cfg_data  <= CFG_W'(stride);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One line: mostly complete short lines, some cut short, some run past the end.
  task automatic draw_random_line(ref int budget);
    int kind;
    int xs;
    int ys;
    int xe;
    int ye;
    int major;
    int strokes;
    kind = $urandom_range(99);
    xs   = $urandom_range(COORD_MAX);
    ys   = $urandom_range(COORD_MAX);
    if (kind < 3) begin
      xe = $urandom_range(COORD_MAX);
      ye = $urandom_range(COORD_MAX);
    end else begin
      xe = clamp_coord(xs + $urandom_range(30) - 15);
      ye = clamp_coord(ys + $urandom_range(30) - 15);
    end
    major = (xe > xs ? xe - xs : xs - xe);
    if ((ye > ys ? ye - ys : ys - ye) > major) major = (ye > ys ? ye - ys : ys - ye);
    strokes = major;
    if (kind >= 80 && kind < 90) begin
      strokes = $urandom_range(major);
    end else if (kind >= 90) begin
      strokes = major + $urandom_range(3, 1);
    end
    offer_command(OP_START, xs, ys, xe, ye);
    budget--;
    for (int i = 0; i < strokes && (i >= major || budget > 0); i++) begin
      offer_step();
      if (i < major) budget--;
    end
  endtask

  initial begin : stimulus
    int budget;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines at the reset register values
    offer_step();
    offer_command(OP_START, 0, 0, 0, 0);
    offer_step();
    offer_command(OP_START, COORD_MAX, COORD_MAX, 0, 0);
    offer_step();
    offer_step();
    offer_command(OP_START, 0, COORD_MAX, COORD_MAX, 0);
    offer_step();
    offer_command(OP_START, COORD_MAX, 0, COORD_MAX - 4, 2);
    repeat (4) offer_step();
    offer_step();
    offer_command(OP_START, 10, 20, 10, 23);
    repeat (3) offer_step();
    offer_command(OP_START, 700, 5, 702, 5);
    repeat (2) offer_step();
    offer_command(OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    drain_pixels();

    for (int p = 0; p < 3; p++) begin
      phase           <= p;
      sender_idle_pct  = (p == 0) ? 36 : ((p == 1) ? 59 : 0);
      recv_idle_pct   <= (p == 0) ? 59 : ((p == 1) ? 36 : 0);
      for (int c = 0; c < 4; c++) begin
        if (c == 3) begin
          load_settings($urandom_range(63), $urandom_range(16383));
        end else begin
          load_settings(bpp_set[p*3+c], stride_set[p*3+c]);
        end
        budget = CHUNK_WORDS;
        while (budget > 0) draw_random_line(budget);
        drain_pixels();
      end
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
